// File: rtl/acb_pkg.sv
// ----------------------------------------------------------------------------
// acb_pkg
// Shared types, constants and GF(2^8) tables for the block cipher pipeline.
// The field is reduced by 0x169.
// ----------------------------------------------------------------------------
package acb_pkg;

    localparam int ROUNDS   = 10;
    localparam int STAGES   = ROUNDS + 1;
    localparam int BLK_W    = 128;
    localparam int HALF_W   = 64;
    localparam int BYTES    = BLK_W / 8;
    localparam int STEP_W   = $clog2(ROUNDS + 1);

    localparam logic [8:0] GF_POLY   = 9'h169;
    localparam logic [7:0] FWD_CONST = 8'h15;
    localparam logic [7:0] INV_CONST = 8'hC7;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    localparam logic KIND_ENC = 1'b0;
    localparam logic KIND_DEC = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [HALF_W-1:0] block_high;
        logic [HALF_W-1:0] block_low;
    } blk_in_t;

    typedef struct packed {
        logic [HALF_W-1:0] out_high;
        logic [HALF_W-1:0] out_low;
    } blk_out_t;

    typedef logic [ROUNDS:0][BLK_W-1:0] rk_set_t;

    typedef struct packed {
        logic busy;
    } ks_status_t;

    typedef logic [7:0] byte_table_t [256];

    function automatic logic [7:0] gf_dbl(input logic [7:0] a);
        logic [8:0] t;
        t = {a, 1'b0};
        if (t[8])
        begin
            t = t ^ GF_POLY;
        end
        return t[7:0];
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x   = a;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
            begin
                acc = acc ^ x;
            end
            x = gf_dbl(x);
        end
        return acc;
    endfunction

    function automatic logic [7:0] gf_inv(input logic [7:0] a);
        logic [7:0] r;
        logic [7:0] base;
        logic [7:0] e;
        r    = 8'h01;
        base = a;
        e    = 8'd254;
        for (int k = 0; k < 8; k++)
        begin
            if (e[k])
            begin
                r = gf_mul(r, base);
            end
            base = gf_mul(base, base);
        end
        return r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] x, input int r);
        logic [15:0] d;
        d = {x, x} << r;
        return d[15:8];
    endfunction

    function automatic byte_table_t build_fwd();
        byte_table_t t;
        logic [7:0]  m;
        for (int i = 0; i < 256; i++)
        begin
            m = gf_inv(8'(i));
            t[i] = m ^ rotl8(m, 1) ^ rotl8(m, 2) ^ rotl8(m, 3) ^ rotl8(m, 4) ^ FWD_CONST;
        end
        return t;
    endfunction

    function automatic byte_table_t build_inv();
        byte_table_t t;
        logic [7:0]  x;
        logic [7:0]  m;
        for (int i = 0; i < 256; i++)
        begin
            x = 8'(i);
            m = rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ INV_CONST;
            t[i] = gf_inv(m);
        end
        return t;
    endfunction

    localparam byte_table_t SBOX_FWD = build_fwd();
    localparam byte_table_t SBOX_INV = build_inv();

endpackage

// File: rtl/aes128_variant_block_cipher_top.sv
// ----------------------------------------------------------------------------
// aes128_variant_block_cipher_top
// Ten-round block cipher over GF(2^8) mod 0x169, encrypt or decrypt per block.
// ----------------------------------------------------------------------------
// Blocks enter at one per cycle while blk_stall is low and pass through one
// register for the initial key addition and one per round. Each stage moves on its own
// whenever the stage after it has room, so bubbles close up under output
// stall. After reset and after every key write the round keys are expanded
// one per cycle, and blk_stall stays high while they expand.
module aes128_variant_block_cipher_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              blk_valid,
    output logic              blk_stall,
    input  acb_pkg::blk_in_t  blk_data,
    output logic              res_valid,
    input  logic              res_stall,
    output acb_pkg::blk_out_t res_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [63:0]       cfg_data
);
    import acb_pkg::*;

    rk_set_t          rkeys;
    ks_status_t       ks_status;
    logic [STAGES-1:0] v;
    logic [STAGES-1:0] dec;
    logic [STAGES-1:0] adv;
    logic [BLK_W-1:0] st [STAGES];
    logic             v0_reg;
    logic             dec0_reg;
    logic [BLK_W-1:0] st0_reg;
    logic [BLK_W-1:0] st0_next;
    logic             take;

    acb_keysched u_keysched (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .rkeys     (rkeys),
        .status    (ks_status)
    );

    assign adv[STAGES-1] = !v[STAGES-1] || !res_stall;

    generate
        for (genvar i = 0; i < STAGES - 1; i++)
        begin : g_adv
            assign adv[i] = !v[i] || adv[i+1];
        end
    endgenerate

    assign blk_stall = !adv[0] || ks_status.busy;
    assign take      = blk_valid && !ks_status.busy;
    assign st0_next  = {blk_data.block_high, blk_data.block_low}
                     ^ ((blk_data.kind == KIND_DEC) ? rkeys[ROUNDS] : rkeys[0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv[0])
        begin
            v0_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dec0_reg <= blk_data.kind;
            st0_reg  <= st0_next;
        end
    end

    assign v[0]   = v0_reg;
    assign dec[0] = dec0_reg;
    assign st[0]  = st0_reg;

    generate
        for (genvar k = 1; k < STAGES; k++)
        begin : g_round
            acb_round u_round (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv[k]),
                .in_valid  (v[k-1]),
                .in_dec    (dec[k-1]),
                .in_state  (st[k-1]),
                .key_enc   (rkeys[k]),
                .key_dec   (rkeys[ROUNDS-k]),
                .last      (1'(k == ROUNDS)),
                .out_valid (v[k]),
                .out_dec   (dec[k]),
                .out_state (st[k])
            );
        end
    endgenerate

    assign res_valid         = v[STAGES-1];
    assign res_data.out_high = st[STAGES-1][BLK_W-1:HALF_W];
    assign res_data.out_low  = st[STAGES-1][HALF_W-1:0];

`ifndef SYNTHESIS
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        ks_status.busy |-> blk_stall)
        else $error("input transfer while round keys expand");

    a_cfg_starts_expand: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> ks_status.busy)
        else $error("key write did not start expansion");

    a_held_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res_data)))
        else $error("stalled result dropped from last stage");
`endif

endmodule

// File: rtl/acb_keysched.sv
// ----------------------------------------------------------------------------
// acb_keysched
// Key registers and round key expansion, one round key per cycle.
// ----------------------------------------------------------------------------
module acb_keysched (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic                      cfg_index,
    input  logic [63:0]               cfg_data,
    output logic                      cfg_ready,
    output acb_pkg::rk_set_t          rkeys,
    output acb_pkg::ks_status_t       status
);
    import acb_pkg::*;

    logic [HALF_W-1:0] key_high_reg;
    logic [HALF_W-1:0] key_low_reg;
    logic [HALF_W-1:0] key_high_next;
    logic [HALF_W-1:0] key_low_next;
    logic [BLK_W-1:0]  cur_reg;
    logic [BLK_W-1:0]  cur_next;
    logic [7:0]        rc_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              cfg_fire;
    logic [BLK_W-1:0]  rk_reg [1:ROUNDS];

    function automatic logic [BLK_W-1:0] expand_next(input logic [BLK_W-1:0] p,
                                                     input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
        w0 = p[127:96];
        w1 = p[95:64];
        w2 = p[63:32];
        w3 = p[31:0];
        t  = {SBOX_FWD[w3[23:16]], SBOX_FWD[w3[15:8]], SBOX_FWD[w3[7:0]], SBOX_FWD[w3[31:24]]};
        t  = t ^ {rc, 24'h000000};
        n0 = w0 ^ t;
        n1 = w1 ^ n0;
        n2 = w2 ^ n1;
        n3 = w3 ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid & cfg_ready;
    assign key_high_next = (cfg_index == CFG_KEY_HIGH) ? cfg_data : key_high_reg;
    assign key_low_next  = (cfg_index == CFG_KEY_LOW) ? cfg_data : key_low_reg;
    assign cur_next      = expand_next(cur_reg, rc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            cur_reg      <= '0;
            rc_reg       <= 8'h01;
            step_reg     <= STEP_W'(1);
            busy_reg     <= 1'b1;
        end
        else if (cfg_fire)
        begin
            key_high_reg <= key_high_next;
            key_low_reg  <= key_low_next;
            cur_reg      <= {key_high_next, key_low_next};
            rc_reg       <= 8'h01;
            step_reg     <= STEP_W'(1);
            busy_reg     <= 1'b1;
        end
        else if (busy_reg)
        begin
            cur_reg  <= cur_next;
            rc_reg   <= gf_dbl(rc_reg);
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(ROUNDS))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !cfg_fire)
        begin
            rk_reg[step_reg] <= cur_next;
        end
    end

    always_comb
    begin
        rkeys[0] = {key_high_reg, key_low_reg};
        for (int i = 1; i <= ROUNDS; i++)
        begin
            rkeys[i] = rk_reg[i];
        end
    end

    assign status.busy = busy_reg;

endmodule

// File: rtl/acb_round.sv
// ----------------------------------------------------------------------------
// acb_round
// One registered cipher round, forward or inverse per item.
// ----------------------------------------------------------------------------
module acb_round (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  logic        in_dec,
    input  logic [127:0] in_state,
    input  logic [127:0] key_enc,
    input  logic [127:0] key_dec,
    input  logic        last,
    output logic        out_valid,
    output logic        out_dec,
    output logic [127:0] out_state
);
    import acb_pkg::*;

    logic              valid_reg;
    logic              dec_reg;
    logic [BLK_W-1:0]  state_reg;
    logic [BLK_W-1:0]  state_next;
    logic [BLK_W-1:0]  enc_res;
    logic [BLK_W-1:0]  dec_res;

    function automatic logic [7:0] gb(input logic [BLK_W-1:0] s, input int n);
        return s[BLK_W-1-8*n -: 8];
    endfunction

    function automatic logic [BLK_W-1:0] sub_all(input logic [BLK_W-1:0] s, input logic inv);
        logic [BLK_W-1:0] t;
        for (int n = 0; n < BYTES; n++)
        begin
            t[BLK_W-1-8*n -: 8] = inv ? SBOX_INV[gb(s, n)] : SBOX_FWD[gb(s, n)];
        end
        return t;
    endfunction

    function automatic logic [BLK_W-1:0] shift_all(input logic [BLK_W-1:0] s, input logic inv);
        logic [BLK_W-1:0] t;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (inv)
                begin
                    t[BLK_W-1-8*(4*c+r) -: 8] = gb(s, 4*((c-r+4)%4)+r);
                end
                else
                begin
                    t[BLK_W-1-8*(4*c+r) -: 8] = gb(s, 4*((c+r)%4)+r);
                end
            end
        end
        return t;
    endfunction

    function automatic logic [BLK_W-1:0] mix_all(input logic [BLK_W-1:0] s, input logic inv);
        logic [BLK_W-1:0] t;
        logic [7:0]       k [4];
        logic [7:0]       v;
        if (inv)
        begin
            k = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        end
        else
        begin
            k = '{8'h02, 8'h03, 8'h01, 8'h01};
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                v = 8'h00;
                for (int j = 0; j < 4; j++)
                begin
                    v = v ^ gf_mul(gb(s, 4*c+j), k[(j+4-r)%4]);
                end
                t[BLK_W-1-8*(4*c+r) -: 8] = v;
            end
        end
        return t;
    endfunction

    always_comb
    begin
        enc_res = shift_all(sub_all(in_state, 1'b0), 1'b0);
        if (!last)
        begin
            enc_res = mix_all(enc_res, 1'b0);
        end
        enc_res = enc_res ^ key_enc;
        dec_res = sub_all(shift_all(in_state, 1'b1), 1'b1) ^ key_dec;
        if (!last)
        begin
            dec_res = mix_all(dec_res, 1'b1);
        end
        state_next = (in_dec == KIND_DEC) ? dec_res : enc_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dec_reg   <= in_dec;
            state_reg <= state_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_dec   = dec_reg;
    assign out_state = state_reg;

endmodule
